### rtl/bpa_pkg.sv
// Package for the buddy page allocator: payload types, codes, widths and
// helper functions for the tree build and order arithmetic. No dependencies.
`default_nettype none

package bpa_pkg;

  localparam int LEVELS     = 12;
  localparam int NODE_W     = LEVELS + 1;          // tree node index, root at 1
  localparam int TREE_DEPTH = 1 << (LEVELS + 1);
  localparam int PAGE_W     = LEVELS;
  localparam int CNT_W      = LEVELS + 1;          // page counts up to 2^LEVELS
  localparam int ORD_W      = $clog2(LEVELS + 2);  // orders and tree values
  localparam logic [CNT_W-1:0] POOL_PAGES = CNT_W'(1) << LEVELS;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;

  typedef struct packed {
    logic              op;
    logic [12:0]       size_pages;
    logic [11:0]       base_page;
  } bpa_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [11:0]       page_index;
    logic [12:0]       pages_avail;
  } bpa_out_t;

  // free block count per order
  typedef logic [LEVELS:0][CNT_W-1:0] cnt_vec_t;

  // position of the highest set bit
  function automatic logic [ORD_W-1:0] msb_pos(input logic [NODE_W:0] v);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int i = 0; i <= NODE_W; i++) begin
      if (v[i]) r = ORD_W'(i);
    end
    return r;
  endfunction

  // position of the lowest set bit
  function automatic logic [ORD_W-1:0] lsb_pos(input logic [NODE_W:0] v);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int i = NODE_W; i >= 0; i--) begin
      if (v[i]) r = ORD_W'(i);
    end
    return r;
  endfunction

  // smallest k with 2^k >= v, v nonzero
  function automatic logic [ORD_W-1:0] ceil_log2(input logic [CNT_W-1:0] v);
    logic [ORD_W-1:0] m;
    m = msb_pos({1'b0, v});
    if ((v & (v - CNT_W'(1))) != '0) m = m + ORD_W'(1);
    return m;
  endfunction

  // tree value of one node for a freshly built pool of pool pages
  function automatic logic [ORD_W-1:0] build_val(input logic [NODE_W-1:0] node,
                                                 input logic [CNT_W-1:0]  pool);
    logic [ORD_W-1:0] p;
    logic [ORD_W-1:0] ord;
    logic [NODE_W-1:0] idx;
    logic [CNT_W:0] start;
    logic [CNT_W:0] stop;
    logic [CNT_W:0] rem;
    p     = msb_pos({1'b0, node});
    ord   = ORD_W'(LEVELS) - p;
    idx   = node & ~(NODE_W'(1) << p);
    start = (CNT_W+1)'(idx) << ord;
    stop  = start + ((CNT_W+1)'(1) << ord);
    rem   = {1'b0, pool} - start;
    if ({1'b0, pool} >= stop) return ord + ORD_W'(1);
    else if ({1'b0, pool} <= start) return '0;
    else return msb_pos(rem) + ORD_W'(1);
  endfunction

  // greedy decomposition: one free block per set bit of the pool size
  function automatic cnt_vec_t init_cnt(input logic [CNT_W-1:0] pool);
    cnt_vec_t c;
    for (int o = 0; o <= LEVELS; o++) begin
      c[o] = CNT_W'(pool[o]);
    end
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_pool(input logic [12:0] m);
    return (CNT_W'(m) > POOL_PAGES) ? POOL_PAGES : CNT_W'(m);
  endfunction

endpackage

`default_nettype wire

### rtl/bpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read of an address written in the same cycle returns the old data.
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/buddy_page_allocator_unit.sv
// Buddy page allocator top level: tree memory, per-order free counters and
// the sequencer. Depends on bpa_pkg and bpa_ram.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_word) carries one request word:
//    allocate (size rounded up to a power of two) or free (aligned block).
//  - Output channel (out_valid / out_stall / out_word) returns one result word
//    per request: status, first page of the allocated block, free page total.
//  - cfg_we / cfg_wdata set managed_pages; this rebuilds the pool and drops
//    every allocation. Write only while the block is idle.
//  - One request in flight. A request rejected in the check step ends there;
//    a free descends from the root to its block, checking each level, then
//    writes it and fixes up the levels to the root, merging buddies; an
//    alloc searches for the leftmost free block of the wanted order, splits
//    it down to the request's order and fixes up the levels to the root.
//    Each step makes at most one access of the single-port-pair tree RAM
//    (registered read data), which sets the pace; larger blocks take fewer
//    steps than a single page, and each extra node that a search visits
//    adds a read step and an evaluate step.
//  - After reset and after each config write the tree is rebuilt by a sweep
//    over all 2^(LEVELS+1)-1 = 8191 nodes, one node per cycle; in_stall
//    stays high meanwhile.
//  - A finished result sits in the output register until taken; a new
//    request is taken meanwhile, and only its result waits on out_stall.
//  - Accesses to one node never overlap: each read is issued only after the
//    last write to that node has landed, so no forwarding path exists.
`default_nettype none

module buddy_page_allocator_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bpa_pkg::bpa_in_t  in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bpa_pkg::bpa_out_t      out_word,
  input  wire logic              cfg_we,
  input  wire logic [12:0]       cfg_wdata
);

  import bpa_pkg::*;

  typedef enum logic [11:0] {
    ST_INIT    = 12'b0000_0000_0001,
    ST_IDLE    = 12'b0000_0000_0010,
    ST_CHECK   = 12'b0000_0000_0100,
    ST_DFS_RD  = 12'b0000_0000_1000,
    ST_DFS_EV  = 12'b0000_0001_0000,
    ST_SPLIT_L = 12'b0000_0010_0000,
    ST_SPLIT_R = 12'b0000_0100_0000,
    ST_LEAF    = 12'b0000_1000_0000,
    ST_FIX_RD  = 12'b0001_0000_0000,
    ST_FIX_WR  = 12'b0010_0000_0000,
    ST_FD_RD   = 12'b0100_0000_0000,
    ST_FD_EV   = 12'b1000_0000_0000
  } state_t;

  // DONE shares no code with others; kept as a separate one-hot register bit
  logic done_r, done_nxt;

  state_t            state_r, state_nxt;
  logic [12:0]       managed_r, managed_nxt;
  logic [CNT_W-1:0]  free_total_r, free_total_nxt;
  cnt_vec_t          cnt_r, cnt_nxt;
  logic              op_r, op_nxt;
  logic [12:0]       size_r, size_nxt;
  logic [11:0]       base_r, base_nxt;
  logic [ORD_W-1:0]  k_r, k_nxt;
  logic [ORD_W-1:0]  want_r, want_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [ORD_W-1:0]  ord_r, ord_nxt;
  logic [ORD_W-1:0]  cur_val_r, cur_val_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic              out_valid_r, out_valid_nxt;
  bpa_out_t          out_word_r, out_word_nxt;

  // tree RAM port
  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  logic [ORD_W-1:0]  ram_wdata;
  logic [NODE_W-1:0] ram_raddr;
  logic [ORD_W-1:0]  ram_rdata;

  bpa_ram #(
    .WIDTH (ORD_W),
    .DEPTH (TREE_DEPTH)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // counter update requests
  logic              dec_en, dec_two, inc_en;
  logic [ORD_W-1:0]  dec_idx, inc_idx;

  logic [CNT_W-1:0]  pool;
  logic              out_free;

  // check-step terms
  logic [ORD_W-1:0]  k_c;
  logic [ORD_W-1:0]  j_c;
  logic              j_found;
  logic [12:0]       size_m1;
  logic [13:0]       blk_end;

  // search / fix-up terms
  logic [NODE_W:0]   bt_n1;
  logic [ORD_W-1:0]  bt_tz;
  logic [ORD_W-1:0]  lv, rv, po, comb_val;
  logic [ORD_W-1:0]  bit_sel;

  assign pool     = clamp_pool(managed_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || done_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign k_c     = ceil_log2(size_r);
  assign size_m1 = size_r - 13'd1;
  assign blk_end = {2'b00, base_r} + {1'b0, size_r};

  // lowest order at or above k that still has a free block
  always_comb begin
    j_c     = '0;
    j_found = 1'b0;
    for (int o = LEVELS; o >= 0; o--) begin
      if (ORD_W'(o) >= k_c && cnt_r[o] != '0) begin
        j_c     = ORD_W'(o);
        j_found = 1'b1;
      end
    end
  end

  // backtrack: climb while a right child, then step to the right sibling
  assign bt_n1 = {1'b0, node_r} + (NODE_W+1)'(1);
  assign bt_tz = lsb_pos(bt_n1);

  assign lv       = node_r[0] ? ram_rdata : cur_val_r;
  assign rv       = node_r[0] ? cur_val_r : ram_rdata;
  assign po       = ord_r + ORD_W'(1);
  assign comb_val = (lv == po && rv == po) ? po + ORD_W'(1) : ((lv > rv) ? lv : rv);
  assign bit_sel  = ord_r - ORD_W'(1);

  always_comb begin
    state_nxt      = state_r;
    done_nxt       = done_r;
    managed_nxt    = managed_r;
    free_total_nxt = free_total_r;
    op_nxt         = op_r;
    size_nxt       = size_r;
    base_nxt       = base_r;
    k_nxt          = k_r;
    want_nxt       = want_r;
    node_nxt       = node_r;
    ord_nxt        = ord_r;
    cur_val_nxt    = cur_val_r;
    status_nxt     = status_r;
    page_nxt       = page_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    ram_we         = 1'b0;
    ram_waddr      = node_r;
    ram_wdata      = '0;
    ram_raddr      = node_r;
    dec_en         = 1'b0;
    dec_two        = 1'b0;
    dec_idx        = '0;
    inc_en         = 1'b0;
    inc_idx        = '0;

    if (done_r) begin
      if (out_free) begin
        out_valid_nxt            = 1'b1;
        out_word_nxt.status      = status_r;
        out_word_nxt.page_index  = (status_r == STAT_OK) ? page_r : '0;
        out_word_nxt.pages_avail = free_total_r;
        done_nxt                 = 1'b0;
      end
    end else begin
      case (state_r)
        ST_INIT: begin
          ram_we    = 1'b1;
          ram_waddr = node_r;
          ram_wdata = build_val(node_r, pool);
          node_nxt  = node_r + NODE_W'(1);
          if (node_r == '1) state_nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            op_nxt    = in_word.op;
            size_nxt  = in_word.size_pages;
            base_nxt  = in_word.base_page;
            state_nxt = ST_CHECK;
          end
        end
        ST_CHECK: begin
          k_nxt    = k_c;
          page_nxt = '0;
          node_nxt = NODE_W'(1);
          ord_nxt  = ORD_W'(LEVELS);
          if (size_r == '0) begin
            status_nxt = STAT_BAD;
            state_nxt  = ST_IDLE;
            done_nxt   = 1'b1;
          end else if (op_r == OP_ALLOC) begin
            if (size_r > free_total_r || k_c > ORD_W'(LEVELS) || !j_found) begin
              status_nxt = STAT_NOSPACE;
              state_nxt  = ST_IDLE;
              done_nxt   = 1'b1;
            end else begin
              want_nxt  = j_c;
              state_nxt = ST_DFS_RD;
            end
          end else begin
            if ((size_r & size_m1) != '0 || k_c > ORD_W'(LEVELS) ||
                (base_r & size_m1[11:0]) != '0 || blk_end > {1'b0, pool}) begin
              status_nxt = STAT_BAD;
              state_nxt  = ST_IDLE;
              done_nxt   = 1'b1;
            end else begin
              state_nxt = ST_FD_RD;
            end
          end
        end
        ST_DFS_RD: begin
          ram_raddr = node_r;
          state_nxt = ST_DFS_EV;
        end
        ST_DFS_EV: begin
          if (ram_rdata == ord_r + ORD_W'(1) && ord_r == want_r) begin
            // leftmost free block of the wanted order
            dec_en    = 1'b1;
            dec_idx   = want_r;
            state_nxt = (ord_r == k_r) ? ST_LEAF : ST_SPLIT_L;
          end else if (ram_rdata == ord_r + ORD_W'(1) || ord_r <= want_r ||
                       ram_rdata < want_r + ORD_W'(1)) begin
            if (bt_n1 == ((NODE_W+1)'(1) << bt_tz)) begin
              // search ran off the tree; counters said otherwise
              status_nxt = STAT_NOSPACE;
              state_nxt  = ST_IDLE;
              done_nxt   = 1'b1;
            end else begin
              node_nxt  = NODE_W'(bt_n1 >> bt_tz);
              ord_nxt   = ord_r + bt_tz;
              state_nxt = ST_DFS_RD;
            end
          end else begin
            node_nxt  = {node_r[NODE_W-2:0], 1'b0};
            ord_nxt   = ord_r - ORD_W'(1);
            state_nxt = ST_DFS_RD;
          end
        end
        ST_SPLIT_L: begin
          ram_we    = 1'b1;
          ram_waddr = {node_r[NODE_W-2:0], 1'b0};
          ram_wdata = ord_r;
          state_nxt = ST_SPLIT_R;
        end
        ST_SPLIT_R: begin
          // upper half stays free
          ram_we    = 1'b1;
          ram_waddr = {node_r[NODE_W-2:0], 1'b1};
          ram_wdata = ord_r;
          inc_en    = 1'b1;
          inc_idx   = ord_r - ORD_W'(1);
          node_nxt  = {node_r[NODE_W-2:0], 1'b0};
          ord_nxt   = ord_r - ORD_W'(1);
          state_nxt = (ord_r - ORD_W'(1) == k_r) ? ST_LEAF : ST_SPLIT_L;
        end
        ST_LEAF: begin
          ram_we         = 1'b1;
          ram_waddr      = node_r;
          ram_wdata      = '0;
          cur_val_nxt    = '0;
          page_nxt       = PAGE_W'((node_r ^ (NODE_W'(1) << (ORD_W'(LEVELS) - ord_r)))
                                   << ord_r);
          free_total_nxt = free_total_r - (CNT_W'(1) << k_r);
          status_nxt     = STAT_OK;
          if (node_r == NODE_W'(1)) begin
            state_nxt = ST_IDLE;
            done_nxt  = 1'b1;
          end else begin
            state_nxt = ST_FIX_RD;
          end
        end
        ST_FIX_RD: begin
          ram_raddr = node_r ^ NODE_W'(1);
          state_nxt = ST_FIX_WR;
        end
        ST_FIX_WR: begin
          ram_we      = 1'b1;
          ram_waddr   = node_r >> 1;
          ram_wdata   = comb_val;
          cur_val_nxt = comb_val;
          node_nxt    = node_r >> 1;
          ord_nxt     = po;
          if (lv == po && rv == po) begin
            // buddies merge
            dec_en  = 1'b1;
            dec_two = 1'b1;
            dec_idx = ord_r;
            inc_en  = 1'b1;
            inc_idx = po;
          end
          if ((node_r >> 1) == NODE_W'(1)) begin
            state_nxt = ST_IDLE;
            done_nxt  = 1'b1;
          end else begin
            state_nxt = ST_FIX_RD;
          end
        end
        ST_FD_RD: begin
          ram_raddr = node_r;
          state_nxt = ST_FD_EV;
        end
        ST_FD_EV: begin
          if (ord_r > k_r) begin
            if (ram_rdata == ord_r + ORD_W'(1)) begin
              status_nxt = STAT_BAD;
              state_nxt  = ST_IDLE;
              done_nxt   = 1'b1;
            end else begin
              node_nxt  = {node_r[NODE_W-2:0], base_r[bit_sel]};
              ord_nxt   = ord_r - ORD_W'(1);
              state_nxt = ST_FD_RD;
            end
          end else if (ram_rdata != '0) begin
            status_nxt = STAT_BAD;
            state_nxt  = ST_IDLE;
            done_nxt   = 1'b1;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = node_r;
            ram_wdata      = k_r + ORD_W'(1);
            cur_val_nxt    = k_r + ORD_W'(1);
            inc_en         = 1'b1;
            inc_idx        = k_r;
            free_total_nxt = free_total_r + size_r;
            status_nxt     = STAT_OK;
            if (node_r == NODE_W'(1)) begin
              state_nxt = ST_IDLE;
              done_nxt  = 1'b1;
            end else begin
              state_nxt = ST_FIX_RD;
            end
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end

    // per-order free block counters
    for (int o = 0; o <= LEVELS; o++) begin
      cnt_nxt[o] = cnt_r[o];
      if (dec_en && dec_idx == ORD_W'(o))
        cnt_nxt[o] = cnt_nxt[o] - (dec_two ? CNT_W'(2) : CNT_W'(1));
      if (inc_en && inc_idx == ORD_W'(o))
        cnt_nxt[o] = cnt_nxt[o] + CNT_W'(1);
    end

    // pool rebuild
    if (cfg_we) begin
      managed_nxt    = cfg_wdata;
      free_total_nxt = clamp_pool(cfg_wdata);
      cnt_nxt        = init_cnt(clamp_pool(cfg_wdata));
      node_nxt       = NODE_W'(1);
      state_nxt      = ST_INIT;
      done_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      done_r       <= 1'b0;
      managed_r    <= 13'(POOL_PAGES);
      free_total_r <= POOL_PAGES;
      cnt_r        <= init_cnt(POOL_PAGES);
      node_r       <= NODE_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      done_r       <= done_nxt;
      managed_r    <= managed_nxt;
      free_total_r <= free_total_nxt;
      cnt_r        <= cnt_nxt;
      node_r       <= node_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    size_r     <= size_nxt;
    base_r     <= base_nxt;
    k_r        <= k_nxt;
    want_r     <= want_nxt;
    ord_r      <= ord_nxt;
    cur_val_r  <= cur_val_nxt;
    status_r   <= status_nxt;
    page_r     <= page_nxt;
    out_word_r <= out_word_nxt;
  end

  // free page total never exceeds the pool
  a_free_le_pool: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= pool)
    else $error("free total above pool size");

  // granted block is aligned to its size
  a_page_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && status_r == STAT_OK && op_r == OP_ALLOC) |->
      (page_r & PAGE_W'((CNT_W'(1) << k_r) - CNT_W'(1))) == '0)
    else $error("allocated block misaligned");

  // node 0 is not part of the tree
  a_no_node0: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ram_waddr != '0)
    else $error("write to unused tree node");

  // a request only starts after the rebuild sweep has finished
  a_init_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> $past(state_r == ST_IDLE))
    else $error("request accepted outside idle");

endmodule

`default_nettype wire
